>>> rtl/cpcr_pkg.sv
// cpcr_pkg: item types, fixed-point constants and rounding helpers
// shared by every module of circle_pair_collision_resolver
// no dependencies
package cpcr_pkg;

  typedef struct packed {
    logic signed [23:0] pax;
    logic signed [23:0] pay;
    logic signed [23:0] vax;
    logic signed [23:0] vay;
    logic signed [23:0] pbx;
    logic signed [23:0] pby;
    logic signed [23:0] vbx;
    logic signed [23:0] vby;
  } circ_t;

  typedef struct packed {
    circ_t              c;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [24:0] rvx;
    logic signed [24:0] rvy;
    logic               contact;
    logic               degen;
  } ctx_t;

  typedef struct packed {
    circ_t c;
    logic  contact;
    logic  degen;
  } res_t;

  localparam int SQ_STAGES  = 25;
  localparam int SQ_W       = 50;
  localparam int DIV_STAGES = 17;
  localparam int REM_W      = 41;
  localparam int RECIP_SH   = 28;
  localparam logic [25:0] RECIP_5 = 26'd53687091;
  localparam logic signed [24:0] OVERLAP_MIN = 25'sd655;
  localparam logic [7:0] DIAM_RESET = 8'd50;

  // shift right rounding to nearest, ties away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh800000;
    end
    return 24'(v);
  endfunction

endpackage

>>> rtl/circle_pair_collision_resolver.sv
// circle_pair_collision_resolver: one pair of equal circles per clock, through the
// front, square root, divider and back pipelines plus a two-entry output buffer.
// Throughput is one item per cycle while not stalled, set by the fully pipelined
// 25-stage square root and 17-stage divider. The pipeline stalls only when the
// output buffer holds two unread items. The diameter register must be written
// while no item is in flight. Depends on cpcr_pkg and the cpcr modules.
module circle_pair_collision_resolver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_pos_a_x,
  input  logic signed [23:0] in_pos_a_y,
  input  logic signed [23:0] in_vel_a_x,
  input  logic signed [23:0] in_vel_a_y,
  input  logic signed [23:0] in_pos_b_x,
  input  logic signed [23:0] in_pos_b_y,
  input  logic signed [23:0] in_vel_b_x,
  input  logic signed [23:0] in_vel_b_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_new_pos_a_x,
  output logic signed [23:0] out_new_pos_a_y,
  output logic signed [23:0] out_new_vel_a_x,
  output logic signed [23:0] out_new_vel_a_y,
  output logic signed [23:0] out_new_pos_b_x,
  output logic signed [23:0] out_new_pos_b_y,
  output logic signed [23:0] out_new_vel_b_x,
  output logic signed [23:0] out_new_vel_b_y,
  output logic               out_contact,
  output logic               out_degenerate
);
  import cpcr_pkg::*;

  logic [7:0]  diam_val_r;
  logic        en, push, pop;
  circ_t       c_in;
  logic        fv, sv, dv, bv;
  ctx_t        fctx, sctx, dctx;
  logic [32:0] fs;
  logic [23:0] slen, dlen;
  logic signed [17:0] ux, uy;
  res_t        bres, out_r, skid_r;
  logic        out_v_r, skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_val_r <= DIAM_RESET;
    end else if (cfg_we) begin
      diam_val_r <= cfg_wdata;
    end
  end

  assign c_in.pax = in_pos_a_x;
  assign c_in.pay = in_pos_a_y;
  assign c_in.vax = in_vel_a_x;
  assign c_in.vay = in_vel_a_y;
  assign c_in.pbx = in_pos_b_x;
  assign c_in.pby = in_pos_b_y;
  assign c_in.vbx = in_vel_b_x;
  assign c_in.vby = in_vel_b_y;

  assign en       = !skid_v_r;
  assign in_ready = en;

  cpcr_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .diam(diam_val_r),
    .v_in(in_valid && in_ready), .c_in(c_in),
    .v_out(fv), .ctx_out(fctx), .s_out(fs)
  );

  cpcr_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(fv), .ctx_in(fctx), .s_in(fs),
    .v_out(sv), .ctx_out(sctx), .len_out(slen)
  );

  cpcr_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(sv), .ctx_in(sctx), .len_in(slen),
    .v_out(dv), .ctx_out(dctx), .len_out(dlen), .ux_out(ux), .uy_out(uy)
  );

  cpcr_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .diam(diam_val_r), .v_in(dv), .ctx_in(dctx),
    .len_in(dlen), .ux_in(ux), .uy_in(uy), .v_out(bv), .res_out(bres)
  );

  assign push = en && bv;
  assign pop  = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r) begin
        out_v_r <= push;
      end else if (pop) begin
        out_v_r  <= skid_v_r || push;
        skid_v_r <= skid_v_r && push;
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r) begin
      out_r <= bres;
    end else if (pop) begin
      if (skid_v_r) begin
        out_r  <= skid_r;
        skid_r <= bres;
      end else begin
        out_r <= bres;
      end
    end else if (push) begin
      skid_r <= bres;
    end
  end

  assign out_valid       = out_v_r;
  assign out_new_pos_a_x = out_r.c.pax;
  assign out_new_pos_a_y = out_r.c.pay;
  assign out_new_vel_a_x = out_r.c.vax;
  assign out_new_vel_a_y = out_r.c.vay;
  assign out_new_pos_b_x = out_r.c.pbx;
  assign out_new_pos_b_y = out_r.c.pby;
  assign out_new_vel_b_x = out_r.c.vbx;
  assign out_new_vel_b_y = out_r.c.vby;
  assign out_contact     = out_r.contact;
  assign out_degenerate  = out_r.degen;

endmodule

>>> rtl/cpcr_front.sv
// cpcr_front: centre difference, squared distance and contact test, three stages
// depends on cpcr_pkg
module cpcr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [7:0]          diam,
  input  logic                v_in,
  input  cpcr_pkg::circ_t     c_in,
  output logic                v_out,
  output cpcr_pkg::ctx_t      ctx_out,
  output logic [32:0]         s_out
);
  import cpcr_pkg::*;

  logic signed [24:0] dxf, dyf, rvxf, rvyf;
  logic [24:0]        adx, ady;
  logic [15:0]        cd;
  logic               v1_r, v2_r, v3_r;
  ctx_t               ctx1_r, ctx2_r, ctx3_r;
  logic [15:0]        adx1_r, ady1_r;
  logic               near1_r, zero1_r, near2_r, zero2_r;
  logic [31:0]        sqx2_r, sqy2_r, cd2_r;
  logic [32:0]        s3_r, s_sum;
  ctx_t               ctx1_nxt, ctx3_nxt;

  assign cd   = {diam[7:1], 9'd0};
  assign dxf  = $signed({c_in.pbx[23], c_in.pbx}) - $signed({c_in.pax[23], c_in.pax});
  assign dyf  = $signed({c_in.pby[23], c_in.pby}) - $signed({c_in.pay[23], c_in.pay});
  assign rvxf = $signed({c_in.vbx[23], c_in.vbx}) - $signed({c_in.vax[23], c_in.vax});
  assign rvyf = $signed({c_in.vby[23], c_in.vby}) - $signed({c_in.vay[23], c_in.vay});
  assign adx  = dxf[24] ? 25'(-dxf) : 25'(dxf);
  assign ady  = dyf[24] ? 25'(-dyf) : 25'(dyf);

  always_comb begin
    ctx1_nxt         = '0;
    ctx1_nxt.c       = c_in;
    ctx1_nxt.dx      = dxf[16:0];
    ctx1_nxt.dy      = dyf[16:0];
    ctx1_nxt.rvx     = rvxf;
    ctx1_nxt.rvy     = rvyf;
  end

  assign s_sum = {1'b0, sqx2_r} + {1'b0, sqy2_r};

  always_comb begin
    ctx3_nxt         = ctx2_r;
    ctx3_nxt.degen   = zero2_r;
    ctx3_nxt.contact = near2_r && !zero2_r && (s_sum <= {1'b0, cd2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    cd2_r <= cd * cd;
    if (en) begin
      ctx1_r  <= ctx1_nxt;
      adx1_r  <= adx[15:0];
      ady1_r  <= ady[15:0];
      near1_r <= (adx <= {9'd0, cd}) && (ady <= {9'd0, cd});
      zero1_r <= (dxf == 25'sd0) && (dyf == 25'sd0);
      ctx2_r  <= ctx1_r;
      sqx2_r  <= adx1_r * adx1_r;
      sqy2_r  <= ady1_r * ady1_r;
      near2_r <= near1_r;
      zero2_r <= zero1_r;
      ctx3_r  <= ctx3_nxt;
      s3_r    <= s_sum;
    end
  end

  assign v_out   = v3_r;
  assign ctx_out = ctx3_r;
  assign s_out   = s3_r;

endmodule

>>> rtl/cpcr_isqrt.sv
// cpcr_isqrt: pipelined integer square root of squared distance << 16, one bit per stage
// depends on cpcr_pkg
module cpcr_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_in,
  input  cpcr_pkg::ctx_t  ctx_in,
  input  logic [32:0]     s_in,
  output logic            v_out,
  output cpcr_pkg::ctx_t  ctx_out,
  output logic [23:0]     len_out
);
  import cpcr_pkg::*;

  logic [SQ_W-1:0] n_r   [SQ_STAGES];
  logic [SQ_W-1:0] r_r   [SQ_STAGES];
  ctx_t            ctx_r [SQ_STAGES];
  logic            v_r   [SQ_STAGES];

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
    localparam logic [SQ_W-1:0] B = SQ_W'(1) << (2 * (SQ_STAGES - 1 - i));
    logic [SQ_W-1:0] n_in, r_in, t, n_nxt, r_nxt;
    ctx_t            c_in;
    logic            vi;

    if (i == 0) begin : g_first
      assign n_in = {1'b0, s_in, 16'd0};
      assign r_in = '0;
      assign c_in = ctx_in;
      assign vi   = v_in;
    end else begin : g_next
      assign n_in = n_r[i-1];
      assign r_in = r_r[i-1];
      assign c_in = ctx_r[i-1];
      assign vi   = v_r[i-1];
    end

    always_comb begin
      t = r_in + B;
      if (n_in >= t) begin
        n_nxt = n_in - t;
        r_nxt = (r_in >> 1) + B;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i]   <= n_nxt;
        r_r[i]   <= r_nxt;
        ctx_r[i] <= c_in;
      end
    end
  end

  assign v_out   = v_r[SQ_STAGES-1];
  assign ctx_out = ctx_r[SQ_STAGES-1];
  assign len_out = r_r[SQ_STAGES-1][23:0];

endmodule

>>> rtl/cpcr_div.sv
// cpcr_div: pipelined restoring division giving the unit centre line in Q.16,
// two lanes, one quotient bit per stage; depends on cpcr_pkg
module cpcr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                v_in,
  input  cpcr_pkg::ctx_t      ctx_in,
  input  logic [23:0]         len_in,
  output logic                v_out,
  output cpcr_pkg::ctx_t      ctx_out,
  output logic [23:0]         len_out,
  output logic signed [17:0]  ux_out,
  output logic signed [17:0]  uy_out
);
  import cpcr_pkg::*;

  logic [REM_W-1:0]      rx_r  [DIV_STAGES];
  logic [REM_W-1:0]      ry_r  [DIV_STAGES];
  logic [DIV_STAGES-1:0] qx_r  [DIV_STAGES];
  logic [DIV_STAGES-1:0] qy_r  [DIV_STAGES];
  logic [23:0]           l_r   [DIV_STAGES];
  ctx_t                  ctx_r [DIV_STAGES];
  logic                  v_r   [DIV_STAGES];
  logic [15:0]           mx, my;
  logic [REM_W-1:0]      nx0, ny0;
  logic [DIV_STAGES-1:0] qxf, qyf;

  assign mx  = ctx_in.dx[16] ? 16'(-ctx_in.dx) : ctx_in.dx[15:0];
  assign my  = ctx_in.dy[16] ? 16'(-ctx_in.dy) : ctx_in.dy[15:0];
  assign nx0 = {1'b0, mx, 24'd0} + REM_W'(len_in[23:1]);
  assign ny0 = {1'b0, my, 24'd0} + REM_W'(len_in[23:1]);

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int SH = DIV_STAGES - 1 - j;
    logic [REM_W-1:0]      rx_in, ry_in, dsh, rx_nxt, ry_nxt;
    logic [DIV_STAGES-1:0] qx_in, qy_in;
    logic [23:0]           l_in;
    ctx_t                  c_in;
    logic                  vi, hx, hy;

    if (j == 0) begin : g_first
      assign rx_in = nx0;
      assign ry_in = ny0;
      assign qx_in = '0;
      assign qy_in = '0;
      assign l_in  = len_in;
      assign c_in  = ctx_in;
      assign vi    = v_in;
    end else begin : g_next
      assign rx_in = rx_r[j-1];
      assign ry_in = ry_r[j-1];
      assign qx_in = qx_r[j-1];
      assign qy_in = qy_r[j-1];
      assign l_in  = l_r[j-1];
      assign c_in  = ctx_r[j-1];
      assign vi    = v_r[j-1];
    end

    assign dsh    = REM_W'(l_in) << SH;
    assign hx     = rx_in >= dsh;
    assign hy     = ry_in >= dsh;
    assign rx_nxt = hx ? rx_in - dsh : rx_in;
    assign ry_nxt = hy ? ry_in - dsh : ry_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[j]  <= rx_nxt;
        ry_r[j]  <= ry_nxt;
        qx_r[j]  <= {qx_in[DIV_STAGES-2:0], hx};
        qy_r[j]  <= {qy_in[DIV_STAGES-2:0], hy};
        l_r[j]   <= l_in;
        ctx_r[j] <= c_in;
      end
    end
  end

  assign qxf     = qx_r[DIV_STAGES-1];
  assign qyf     = qy_r[DIV_STAGES-1];
  assign v_out   = v_r[DIV_STAGES-1];
  assign ctx_out = ctx_r[DIV_STAGES-1];
  assign len_out = l_r[DIV_STAGES-1];
  assign ux_out  = ctx_out.dx[16] ? -$signed({1'b0, qxf}) : $signed({1'b0, qxf});
  assign uy_out  = ctx_out.dy[16] ? -$signed({1'b0, qyf}) : $signed({1'b0, qyf});

endmodule

>>> rtl/cpcr_back.sv
// cpcr_back: normal velocity exchange, overlap push-out and saturation, five stages
// depends on cpcr_pkg
module cpcr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [7:0]         diam,
  input  logic               v_in,
  input  cpcr_pkg::ctx_t     ctx_in,
  input  logic [23:0]        len_in,
  input  logic signed [17:0] ux_in,
  input  logic signed [17:0] uy_in,
  output logic               v_out,
  output cpcr_pkg::res_t     res_out
);
  import cpcr_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  ctx_t               ctx1_r, ctx2_r, ctx3_r, ctx4_r;
  res_t               res5_r, res_nxt;
  logic signed [17:0] ux1_r, uy1_r, ux2_r, uy2_r;
  logic signed [42:0] pvx1_r, pvy1_r;
  logic [25:0]        x5_1_r;
  logic [51:0]        qm1_r;
  logic               ovl1_r, ovl2_r, ovl3_r;
  logic signed [24:0] k;
  logic [25:0]        x5;
  logic signed [43:0] vsum;
  logic signed [27:0] vn2_r;
  logic [23:0]        q, c_nxt, c2_r;
  logic [25:0]        q5, rem5;
  logic signed [45:0] dvpx3_r, dvpy3_r;
  logic signed [42:0] cpx3_r, cpy3_r;
  logic signed [30:0] dvx4_r, dvy4_r, dvx, dvy;
  logic signed [19:0] cx4_r, cy4_r, cx, cy;

  assign k  = $signed({1'b0, diam, 16'd0}) - $signed({1'b0, len_in});
  assign x5 = {1'b0, k[23:0], 1'b0} + 26'd2;

  assign vsum  = pvx1_r + pvy1_r;
  assign q     = qm1_r[RECIP_SH+23:RECIP_SH];
  assign q5    = 26'(q) + (26'(q) << 2);
  assign rem5  = x5_1_r - q5;
  assign c_nxt = (rem5 >= 26'd5) ? q + 24'd1 : q;

  assign dvx = ctx3_r.contact ? 31'(rshr(64'(dvpx3_r), 16)) : '0;
  assign dvy = ctx3_r.contact ? 31'(rshr(64'(dvpy3_r), 16)) : '0;
  assign cx  = (ctx3_r.contact && ovl3_r) ? 20'(rshr(64'(cpx3_r), 24)) : '0;
  assign cy  = (ctx3_r.contact && ovl3_r) ? 20'(rshr(64'(cpy3_r), 24)) : '0;

  always_comb begin
    res_nxt.contact = ctx4_r.contact;
    res_nxt.degen   = ctx4_r.degen;
    res_nxt.c.pax   = sat24(32'(ctx4_r.c.pax) - 32'(cx4_r));
    res_nxt.c.pay   = sat24(32'(ctx4_r.c.pay) - 32'(cy4_r));
    res_nxt.c.pbx   = sat24(32'(ctx4_r.c.pbx) + 32'(cx4_r));
    res_nxt.c.pby   = sat24(32'(ctx4_r.c.pby) + 32'(cy4_r));
    res_nxt.c.vax   = sat24(32'(ctx4_r.c.vax) + 32'(dvx4_r));
    res_nxt.c.vay   = sat24(32'(ctx4_r.c.vay) + 32'(dvy4_r));
    res_nxt.c.vbx   = sat24(32'(ctx4_r.c.vbx) - 32'(dvx4_r));
    res_nxt.c.vby   = sat24(32'(ctx4_r.c.vby) - 32'(dvy4_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r  <= ctx_in;
      ux1_r   <= ux_in;
      uy1_r   <= uy_in;
      pvx1_r  <= ux_in * ctx_in.rvx;
      pvy1_r  <= uy_in * ctx_in.rvy;
      x5_1_r  <= x5;
      qm1_r   <= x5 * RECIP_5;
      ovl1_r  <= k > OVERLAP_MIN;
      ctx2_r  <= ctx1_r;
      ux2_r   <= ux1_r;
      uy2_r   <= uy1_r;
      vn2_r   <= 28'(rshr(64'(vsum), 16));
      c2_r    <= c_nxt;
      ovl2_r  <= ovl1_r;
      ctx3_r  <= ctx2_r;
      ovl3_r  <= ovl2_r;
      dvpx3_r <= ux2_r * vn2_r;
      dvpy3_r <= uy2_r * vn2_r;
      cpx3_r  <= ux2_r * $signed({1'b0, c2_r});
      cpy3_r  <= uy2_r * $signed({1'b0, c2_r});
      ctx4_r  <= ctx3_r;
      dvx4_r  <= dvx;
      dvy4_r  <= dvy;
      cx4_r   <= cx;
      cy4_r   <= cy;
      res5_r  <= res_nxt;
    end
  end

  assign v_out   = v5_r;
  assign res_out = res5_r;

endmodule
